// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define NLLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define NLLC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define NLLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/nllc_pkg.sv -----
package nllc_pkg;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  localparam logic [7:0]  BaseLevel  = 8'hE8;
  localparam logic [3:0]  VerbGet    = 4'h1;
  localparam logic [3:0]  VerbSet    = 4'h2;
  localparam logic [3:0]  VerbSave   = 4'h3;
  localparam logic [15:0] AnswerOk   = 16'h0000;
  localparam logic [3:0]  AnswerInfo = 4'h1;
  localparam logic [15:0] AnswerErr  = 16'hFFFF;
  localparam logic [15:0] CountMax   = 16'hFFFF;

  localparam int unsigned RegTrigger   = 0;
  localparam int unsigned RegLightOn   = 1;
  localparam int unsigned RegLedOn     = 2;
  localparam int unsigned RegLedOff    = 3;
  localparam int unsigned RegLedOnLow  = 4;
  localparam int unsigned RegLedOffLow = 5;
  localparam int unsigned RegLowPower  = 6;
  localparam int unsigned RegPower     = 7;
  localparam int unsigned RegMotion    = 8;
  localparam int unsigned RegLight     = 9;

  typedef struct packed {
    logic [15:0] command_word;
    logic        command_valid;
    logic        second_pulse;
    logic [7:0]  motion_sample;
    logic [7:0]  battery_sample;
  } item_t;

  typedef struct packed {
    logic [15:0] response_word;
    logic        response_valid;
    logic        led_drive;
    logic        lamp_drive;
  } result_t;

endpackage

// ----- rtl/night_light_lamp_led_controller.sv -----
// Pipeline: an accepted word is held in the input register and its result word
// in the result register. Throughput: one word per cycle while m_axis_tready
// is high, set by the single combinational pass between the two registers.
// Reset: asynchronous and active low; it clears the register file and the LED
// tick counter, lights the status LED and empties both pipeline registers.
`include "assert_macros.svh"

module night_light_lamp_led_controller #(
  parameter int unsigned REGISTER_COUNT = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // battery_sample, motion_sample, second_pulse, command_valid, command_word
  input  logic [nllc_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // lamp_drive, led_drive, response_valid, response_word
  output logic [nllc_pkg::OutDataW-1:0]  m_axis_tdata
);

  nllc_pkg::item_t   in_item_q;
  logic              in_valid_q, in_valid_d;
  nllc_pkg::result_t out_res_q;
  nllc_pkg::result_t core_res;
  logic              out_valid_q, out_valid_d;
  logic              step;
  logic              in_accept;
  logic              res_lamp_led;
  logic              res_idle_word;
  logic              out_stalled;

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_accept || (in_valid_q && !step);
  assign out_valid_d   = step || (out_valid_q && !m_axis_tready);

  nllc_core #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_item_q),
    .result_o(core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q.battery_sample <= s_axis_tdata[7:0];
      in_item_q.motion_sample  <= s_axis_tdata[15:8];
      in_item_q.second_pulse   <= s_axis_tdata[16];
      in_item_q.command_valid  <= s_axis_tdata[17];
      in_item_q.command_word   <= s_axis_tdata[33:18];
    end
    if (step) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_res_q.response_word, out_res_q.response_valid,
                          out_res_q.led_drive, out_res_q.lamp_drive};

  assign res_lamp_led  = out_res_q.lamp_drive && out_res_q.led_drive;
  assign res_idle_word = !out_res_q.response_valid && (out_res_q.response_word != 16'h0000);
  assign out_stalled   = in_valid_q && out_valid_q && !m_axis_tready;

  `NLLC_ASSERT(led_lamp_excl, !(out_valid_q && res_lamp_led), "LED lit while lamp on")
  `NLLC_ASSERT_IMPL(no_resp_zero, out_valid_q, !res_idle_word, "word set without a command")
  `NLLC_ASSERT_IMPL(stall_cause, !s_axis_tready, out_stalled, "stall without a full pipeline")
  `NLLC_ASSERT_NEXT(step_fills_out, step, out_valid_q, "word missed the result register")

endmodule

// ----- rtl/nllc_core.sv -----
module nllc_core #(
  parameter int unsigned REGISTER_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  nllc_pkg::item_t   item_i,
  output nllc_pkg::result_t result_o
);

  logic [7:0]  rf_q [REGISTER_COUNT];
  logic [7:0]  rf_d [REGISTER_COUNT];
  logic [7:0]  view [REGISTER_COUNT];
  logic        led_lit_q, led_lit_d;
  logic [15:0] led_cnt_q, led_cnt_d;

  logic [7:0]  motion_comp;
  logic [3:0]  verb;
  logic [3:0]  cmd_idx;
  logic        set_en;
  logic [7:0]  rd_val;
  logic [7:0]  light_new;
  logic [7:0]  on_period, off_period;
  logic [15:0] cnt_inc;
  logic [15:0] answer;

  assign motion_comp = item_i.motion_sample + nllc_pkg::BaseLevel - item_i.battery_sample;
  assign verb        = item_i.command_word[15:12];
  assign cmd_idx     = item_i.command_word[11:8];
  assign set_en      = item_i.command_valid && (verb == nllc_pkg::VerbSet);

  always_comb begin
    rd_val = 8'h00;
    for (int i = 0; i < REGISTER_COUNT; i++) begin
      view[i] = rf_q[i];
      if (i == nllc_pkg::RegPower) view[i] = item_i.battery_sample;
      if (i == nllc_pkg::RegMotion) view[i] = motion_comp;
      if (set_en && (cmd_idx == 4'(i))) view[i] = item_i.command_word[7:0];
      if (cmd_idx == 4'(i)) rd_val = view[i];
    end
  end

  always_comb begin
    if (view[nllc_pkg::RegMotion] >= view[nllc_pkg::RegTrigger]) begin
      light_new = view[nllc_pkg::RegLightOn];
    end else if (item_i.second_pulse && (view[nllc_pkg::RegLight] != 8'h00)) begin
      light_new = view[nllc_pkg::RegLight] - 8'd1;
    end else begin
      light_new = view[nllc_pkg::RegLight];
    end
    for (int i = 0; i < REGISTER_COUNT; i++) begin
      rf_d[i] = (i == nllc_pkg::RegLight) ? light_new : view[i];
    end
  end

  always_comb begin
    if (view[nllc_pkg::RegPower] <= view[nllc_pkg::RegLowPower]) begin
      on_period  = view[nllc_pkg::RegLedOnLow];
      off_period = view[nllc_pkg::RegLedOffLow];
    end else begin
      on_period  = view[nllc_pkg::RegLedOn];
      off_period = view[nllc_pkg::RegLedOff];
    end
    cnt_inc   = (led_cnt_q != nllc_pkg::CountMax) ? led_cnt_q + 16'd1 : led_cnt_q;
    led_lit_d = led_lit_q;
    led_cnt_d = cnt_inc;
    if (led_lit_q) begin
      if (cnt_inc >= {8'h00, on_period}) begin
        led_lit_d = 1'b0;
        led_cnt_d = 16'h0000;
      end
    end else begin
      if (cnt_inc >= {8'h00, off_period}) begin
        led_lit_d = 1'b1;
        led_cnt_d = 16'h0000;
      end
    end
  end

  always_comb begin
    answer = 16'h0000;
    if (item_i.command_valid) begin
      case (verb)
        nllc_pkg::VerbGet, nllc_pkg::VerbSet: begin
          answer = {nllc_pkg::AnswerInfo, cmd_idx, rd_val};
        end
        nllc_pkg::VerbSave: begin
          answer = nllc_pkg::AnswerOk;
        end
        default: begin
          answer = nllc_pkg::AnswerErr;
        end
      endcase
    end
  end

  assign result_o.lamp_drive     = (light_new != 8'h00);
  assign result_o.led_drive      = (light_new == 8'h00) && led_lit_d;
  assign result_o.response_valid = item_i.command_valid;
  assign result_o.response_word  = answer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        rf_q[i] <= 8'h00;
      end
      led_lit_q <= 1'b1;
      led_cnt_q <= 16'h0000;
    end else if (step_i) begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        rf_q[i] <= rf_d[i];
      end
      led_lit_q <= led_lit_d;
      led_cnt_q <= led_cnt_d;
    end
  end

endmodule

// ----- sim/night_light_lamp_led_controller_tb.sv -----
module night_light_lamp_led_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_TICKS = 700;

  typedef struct packed {
    nllc_pkg::item_t   stim;
    logic              typed;
    nllc_pkg::result_t want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 23;

  // Positional fields: command_word, command_valid, second_pulse, motion_sample, battery_sample.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{16'h0000, 1'b0, 1'b0, 8'h00, 8'hE8}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{16'h0000, 1'b1, 1'b0, 8'h00, 8'hE8}, 1'b1, '{16'hFFFF, 1'b1, 1'b1, 1'b0}},
    '{'{16'h3000, 1'b1, 1'b0, 8'h00, 8'hE8}, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0}},
    '{'{16'h20FF, 1'b1, 1'b0, 8'h10, 8'hE8}, 1'b0, '0},
    '{'{16'h21FF, 1'b1, 1'b0, 8'h10, 8'hE8}, 1'b0, '0},
    '{'{16'h1100, 1'b1, 1'b0, 8'h10, 8'hE8}, 1'b0, '0},
    '{'{16'h2203, 1'b1, 1'b0, 8'h10, 8'hE8}, 1'b0, '0},
    '{'{16'h2302, 1'b1, 1'b0, 8'h10, 8'hE8}, 1'b0, '0},
    '{'{16'h2401, 1'b1, 1'b0, 8'h10, 8'hE8}, 1'b0, '0},
    '{'{16'h2505, 1'b1, 1'b0, 8'h10, 8'hE8}, 1'b0, '0},
    '{'{16'h2680, 1'b1, 1'b0, 8'h10, 8'hE8}, 1'b0, '0},
    '{'{16'h0000, 1'b0, 1'b0, 8'hFF, 8'hE8}, 1'b0, '0},
    '{'{16'h0000, 1'b0, 1'b1, 8'h00, 8'hE8}, 1'b0, '0},
    '{'{16'h2901, 1'b1, 1'b0, 8'h00, 8'hE8}, 1'b0, '0},
    '{'{16'h0000, 1'b0, 1'b1, 8'h00, 8'hE8}, 1'b0, '0},
    '{'{16'h2740, 1'b1, 1'b0, 8'h00, 8'h50}, 1'b0, '0},
    '{'{16'h28FF, 1'b1, 1'b0, 8'h00, 8'hFF}, 1'b0, '0},
    '{'{16'h1F00, 1'b1, 1'b0, 8'h00, 8'h00}, 1'b0, '0},
    '{'{16'h2FAB, 1'b1, 1'b0, 8'hFF, 8'h00}, 1'b0, '0},
    '{'{16'h1FFF, 1'b1, 1'b1, 8'hFF, 8'hFF}, 1'b0, '0},
    '{'{16'hF123, 1'b1, 1'b0, 8'h00, 8'h80}, 1'b0, '0},
    '{'{16'h4567, 1'b1, 1'b0, 8'h80, 8'h7F}, 1'b0, '0},
    '{'{16'h2040, 1'b1, 1'b0, 8'h00, 8'h00}, 1'b0, '0}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [nllc_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [nllc_pkg::OutDataW-1:0] m_axis_tdata;

  logic [7:0]  regfile_copy [16];
  bit          led_on_now;
  logic [15:0] led_ticks;

  nllc_pkg::result_t pending_drive_words [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          no_idle = 1'b0;

  night_light_lamp_led_controller #(
    .REGISTER_COUNT(REG_COUNT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] reg_get(input logic [3:0] idx);
    if (idx >= REG_COUNT) return 8'h00;
    return regfile_copy[idx];
  endfunction

  function automatic void reg_put(input logic [3:0] idx, input logic [7:0] value);
    if (idx < REG_COUNT) regfile_copy[idx] = value;
  endfunction

  function automatic nllc_pkg::result_t step_night_light(input nllc_pkg::item_t it);
    logic [7:0]  comp;
    logic [3:0]  verb;
    logic [3:0]  idx;
    logic [15:0] answer;
    logic [7:0]  timer;
    logic [7:0]  on_p;
    logic [7:0]  off_p;
    bit          lamp;
    nllc_pkg::result_t r;
    comp = it.motion_sample + nllc_pkg::BaseLevel - it.battery_sample;
    reg_put(4'(nllc_pkg::RegPower), it.battery_sample);
    reg_put(4'(nllc_pkg::RegMotion), comp);
    answer = 16'h0000;
    if (it.command_valid) begin
      verb = it.command_word[15:12];
      idx = it.command_word[11:8];
      if (verb == nllc_pkg::VerbGet) begin
        answer = {nllc_pkg::AnswerInfo, idx, reg_get(idx)};
      end else if (verb == nllc_pkg::VerbSet) begin
        reg_put(idx, it.command_word[7:0]);
        answer = {nllc_pkg::AnswerInfo, idx, reg_get(idx)};
      end else if (verb == nllc_pkg::VerbSave) begin
        answer = nllc_pkg::AnswerOk;
      end else begin
        answer = nllc_pkg::AnswerErr;
      end
    end
    if (reg_get(4'(nllc_pkg::RegMotion)) >= reg_get(4'(nllc_pkg::RegTrigger))) begin
      reg_put(4'(nllc_pkg::RegLight), reg_get(4'(nllc_pkg::RegLightOn)));
    end else if (it.second_pulse) begin
      timer = reg_get(4'(nllc_pkg::RegLight));
      reg_put(4'(nllc_pkg::RegLight), (timer != 8'h00) ? timer - 8'h01 : 8'h00);
    end
    if (reg_get(4'(nllc_pkg::RegPower)) <= reg_get(4'(nllc_pkg::RegLowPower))) begin
      on_p = reg_get(4'(nllc_pkg::RegLedOnLow));
      off_p = reg_get(4'(nllc_pkg::RegLedOffLow));
    end else begin
      on_p = reg_get(4'(nllc_pkg::RegLedOn));
      off_p = reg_get(4'(nllc_pkg::RegLedOff));
    end
    if (led_ticks != nllc_pkg::CountMax) led_ticks = led_ticks + 16'd1;
    if (led_on_now) begin
      if (led_ticks >= {8'h00, on_p}) begin
        led_on_now = 1'b0;
        led_ticks = '0;
      end
    end else begin
      if (led_ticks >= {8'h00, off_p}) begin
        led_on_now = 1'b1;
        led_ticks = '0;
      end
    end
    lamp = reg_get(4'(nllc_pkg::RegLight)) != 8'h00;
    r.lamp_drive = lamp;
    r.led_drive = !lamp && led_on_now;
    r.response_valid = it.command_valid;
    r.response_word = answer;
    return r;
  endfunction

  task automatic send_tick(input nllc_pkg::item_t stim, input bit typed,
                           input nllc_pkg::result_t want);
    int unsigned gap;
    nllc_pkg::result_t model_out;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_idle ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(nllc_pkg::InDataW - $bits(nllc_pkg::item_t)){1'b0}}, stim};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    model_out = step_night_light(stim);
    pending_drive_words.push_back(typed ? want : model_out);
  endtask

  initial begin
    nllc_pkg::item_t it;
    int unsigned pick;
    logic [3:0]  verb;
    logic [3:0]  idx;
    logic [7:0]  value;
    foreach (regfile_copy[i]) regfile_copy[i] = 8'h00;
    led_on_now = 1'b1;
    led_ticks = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_tick(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int n = 0; n < RANDOM_TICKS; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
      it.battery_sample = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
        it.battery_sample = 8'(regfile_copy[nllc_pkg::RegLowPower] + $urandom_range(0, 2) - 1);
      end
      it.motion_sample = 8'($urandom_range(0, 255));
      it.second_pulse = ($urandom_range(0, 3) == 0);
      it.command_valid = ($urandom_range(0, 99) < 35);
      pick = $urandom_range(0, 99);
      if (pick < 40) verb = nllc_pkg::VerbGet;
      else if (pick < 80) verb = nllc_pkg::VerbSet;
      else if (pick < 88) verb = nllc_pkg::VerbSave;
      else verb = 4'($urandom_range(0, 15));
      idx = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 9));
      value = 8'($urandom_range(0, 255));
      if (idx >= nllc_pkg::RegLedOn && idx <= nllc_pkg::RegLedOffLow &&
          $urandom_range(0, 1) == 1) begin
        value = 8'($urandom_range(0, 6));
      end
      it.command_word = {verb, idx, value};
      if (!it.command_valid && $urandom_range(0, 1) == 1) begin
        it.command_word = 16'($urandom_range(0, 65535));
      end
      send_tick(it, 1'b0, '0);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    wait (pending_drive_words.size() == 0);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    int unsigned run;
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (no_idle) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        run = $urandom_range(1, 8);
        stall = $urandom_range(1, 5);
        repeat (run) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
        repeat (stall) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    nllc_pkg::result_t got;
    nllc_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = nllc_pkg::result_t'(m_axis_tdata[$bits(nllc_pkg::result_t)-1:0]);
      if (pending_drive_words.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_drive_words.pop_front();
        if (got.lamp_drive !== want.lamp_drive) begin
          $error("lamp_drive: expected %0b, got %0b", want.lamp_drive, got.lamp_drive);
          fail_count++;
        end
        if (got.led_drive !== want.led_drive) begin
          $error("led_drive: expected %0b, got %0b", want.led_drive, got.led_drive);
          fail_count++;
        end
        if (got.response_valid !== want.response_valid) begin
          $error("response_valid: expected %0b, got %0b", want.response_valid,
                 got.response_valid);
          fail_count++;
        end
        if (got.response_word !== want.response_word) begin
          $error("response_word: expected %h, got %h", want.response_word, got.response_word);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/nllc_pkg.sv
rtl/nllc_core.sv
rtl/night_light_lamp_led_controller.sv
sim/night_light_lamp_led_controller_tb.sv
